[rtl/bencode_stream_parser_defines.svh]
// Assertion macros shared by the bencode stream parser RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BENCODE_STREAM_PARSER_DEFINES_SVH
`define BENCODE_STREAM_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bsp_pkg.sv]
// Types and constants of the bencode stream parser.
// Used by every module of the block; depends on nothing.
package bsp_pkg;

   localparam int DEPTH_W  = 6;
   localparam int LIMIT_W  = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_TOP_EXPECT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEPTH  = 1'd1;

   localparam logic [1:0] TOP_LIST = 2'd1;
   localparam logic [1:0] TOP_DICT = 2'd2;
   localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET = 6'd32;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_INT   = 8'h69;
   localparam logic [7:0] CH_END   = 8'h65;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_DICT  = 8'h64;
   localparam logic [7:0] CH_LIST  = 8'h6c;

   // Largest magnitude that can still be multiplied by ten, and the negative limit.
   localparam logic [63:0] ACC_LIMIT = 64'h1999_9999_9999_9999;
   localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
   localparam logic [3:0]  LAST_DIGIT_OK = 4'd5;

   localparam logic [2:0] EV_PENDING = 3'd0;
   localparam logic [2:0] EV_INT     = 3'd1;
   localparam logic [2:0] EV_LENGTH  = 3'd2;
   localparam logic [2:0] EV_BYTE    = 3'd3;
   localparam logic [2:0] EV_LIST    = 3'd4;
   localparam logic [2:0] EV_DICT    = 3'd5;
   localparam logic [2:0] EV_CLOSE   = 3'd6;
   localparam logic [2:0] EV_ERROR   = 3'd7;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_BAD_BYTE = 3'd1;
   localparam logic [2:0] ERR_OVERFLOW = 3'd2;
   localparam logic [2:0] ERR_NEG      = 3'd3;
   localparam logic [2:0] ERR_TRUNC    = 3'd4;
   localparam logic [2:0] ERR_KEY      = 3'd5;
   localparam logic [2:0] ERR_DEEP     = 3'd6;

   typedef struct packed {
      logic kind;
      logic key;
   } stk_entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic flip;
      logic kind;
   } stk_cmd_type;

   typedef struct packed {
      logic [2:0]         event_res;
      logic [63:0]        value;
      logic               negative;
      logic [DEPTH_W-1:0] nest_level;
      logic               is_key;
      logic               string_end;
      logic               message_done;
      logic [2:0]         error_code;
   } rsp_type;

endpackage

[rtl/bencode_stream_parser.sv]
// Bencode stream parser: one byte per transaction in, one result transaction out.
// A result is registered in the output register, or in the skid register while the output stalls.
// Throughput: one byte per cycle while req_stall is low; the parse step and the stack update
// are combinational, the stack memory being read ahead for the entry a close would expose.
// Reset clears the parse state and loads top_expect 0, max_depth 32; the stack memory is
// not cleared, as only entries written since the buffer began are ever read.
`include "bencode_stream_parser_defines.svh"

module bencode_stream_parser #(
   parameter int DEPTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_first_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_event_res,
   output logic [63:0]                     rsp_value,
   output logic                            rsp_negative,
   output logic [bsp_pkg::DEPTH_W-1:0]     rsp_nest_level,
   output logic                            rsp_is_key,
   output logic                            rsp_string_end,
   output logic                            rsp_message_done,
   output logic [2:0]                      rsp_error_code,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bsp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bsp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [2:0] PH_VALUE     = 3'd0;
   localparam logic [2:0] PH_INT_START = 3'd1;
   localparam logic [2:0] PH_INT_NEG   = 3'd2;
   localparam logic [2:0] PH_INT_DIG   = 3'd3;
   localparam logic [2:0] PH_STR_LEN   = 3'd4;
   localparam logic [2:0] PH_STR_BYTES = 3'd5;
   localparam logic [2:0] PH_DONE      = 3'd6;
   localparam logic [2:0] PH_ERROR     = 3'd7;

   logic [1:0]                     top_expect_ff, top_expect_in;
   logic [bsp_pkg::DEPTH_W-1:0]    max_depth_ff, max_depth_in;
   logic [2:0]                     phase_ff, phase_in;
   logic [63:0]                    acc_ff, acc_in;
   logic                           sign_ff, sign_in;
   logic [63:0]                    left_ff, left_in;
   logic [bsp_pkg::DEPTH_W-1:0]    depth_ff, depth_in;
   logic                           cur_key_ff, cur_key_in;

   logic                           req_accept;
   logic [2:0]                     cph;
   logic [bsp_pkg::DEPTH_W-1:0]    cd;
   bsp_pkg::stk_entry_type         stk_top;
   bsp_pkg::stk_cmd_type           stk_cmd;
   logic                           in_dict;
   logic                           want_key;
   logic                           is_dig;
   logic [3:0]                     dv;
   logic [63:0]                    acc_x10;
   logic                           acc_ovf;
   logic                           too_deep;
   logic                           fin;
   logic [2:0]                     err;
   bsp_pkg::rsp_type               res;
   bsp_pkg::rsp_type               out_data;
   logic                           buf_full;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = buf_full;
   assign csr_ready  = 1'b1;

   assign cph      = req_first_byte ? PH_VALUE : phase_ff;
   assign cd       = req_first_byte ? '0 : depth_ff;
   assign in_dict  = (cd != '0) && stk_top.kind;
   assign want_key = in_dict && stk_top.key;
   assign is_dig   = (req_data_byte >= bsp_pkg::CH_ZERO) && (req_data_byte <= bsp_pkg::CH_NINE);
   assign dv       = req_data_byte[3:0];
   assign acc_x10  = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0} + {60'd0, dv};
   assign acc_ovf  = (acc_ff > bsp_pkg::ACC_LIMIT) ||
                     ((acc_ff == bsp_pkg::ACC_LIMIT) && (dv > bsp_pkg::LAST_DIGIT_OK));
   assign too_deep = (bsp_pkg::LIMIT_W'(cd) >= bsp_pkg::LIMIT_W'(DEPTH)) ||
                     (cd >= max_depth_ff);

   always_comb begin
      top_expect_in = top_expect_ff;
      max_depth_in  = max_depth_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bsp_pkg::CSR_TOP_EXPECT: top_expect_in = csr_wdata[1:0];
            bsp_pkg::CSR_MAX_DEPTH:  max_depth_in  = csr_wdata[bsp_pkg::DEPTH_W-1:0];
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      sign_in    = sign_ff;
      left_in    = left_ff;
      depth_in   = depth_ff;
      cur_key_in = cur_key_ff;
      stk_cmd    = '0;
      res        = '0;
      fin        = 1'b0;
      err        = bsp_pkg::ERR_NONE;
      if (req_accept) begin
         phase_in = cph;
         depth_in = cd;
         unique case (cph)
            PH_VALUE: begin
               priority if (req_data_byte == bsp_pkg::CH_END) begin
                  if (cd == '0) begin
                     err = bsp_pkg::ERR_BAD_BYTE;
                  end else if (in_dict && !want_key) begin
                     err = bsp_pkg::ERR_KEY;
                  end else begin
                     depth_in      = cd - 1'b1;
                     stk_cmd.pop   = 1'b1;
                     res.event_res = bsp_pkg::EV_CLOSE;
                     fin           = 1'b1;
                  end
               end else if (want_key && !is_dig) begin
                  err = bsp_pkg::ERR_KEY;
               end else if ((cd == '0) && (top_expect_ff == bsp_pkg::TOP_LIST) &&
                            (req_data_byte != bsp_pkg::CH_LIST)) begin
                  err = bsp_pkg::ERR_BAD_BYTE;
               end else if ((cd == '0) && (top_expect_ff == bsp_pkg::TOP_DICT) &&
                            (req_data_byte != bsp_pkg::CH_DICT)) begin
                  err = bsp_pkg::ERR_BAD_BYTE;
               end else if ((req_data_byte == bsp_pkg::CH_LIST) ||
                            (req_data_byte == bsp_pkg::CH_DICT)) begin
                  if (too_deep) begin
                     err = bsp_pkg::ERR_DEEP;
                  end else begin
                     stk_cmd.push  = 1'b1;
                     stk_cmd.kind  = (req_data_byte == bsp_pkg::CH_DICT);
                     depth_in      = cd + 1'b1;
                     res.event_res = stk_cmd.kind ? bsp_pkg::EV_DICT : bsp_pkg::EV_LIST;
                  end
               end else if (req_data_byte == bsp_pkg::CH_INT) begin
                  acc_in   = '0;
                  sign_in  = 1'b0;
                  phase_in = PH_INT_START;
               end else if (is_dig) begin
                  acc_in     = {60'd0, dv};
                  cur_key_in = want_key;
                  phase_in   = PH_STR_LEN;
               end else begin
                  err = bsp_pkg::ERR_BAD_BYTE;
               end
            end
            PH_INT_START: begin
               if (req_data_byte == bsp_pkg::CH_MINUS) begin
                  sign_in  = 1'b1;
                  phase_in = PH_INT_NEG;
               end else if (is_dig) begin
                  acc_in   = {60'd0, dv};
                  phase_in = PH_INT_DIG;
               end else begin
                  err = bsp_pkg::ERR_BAD_BYTE;
               end
            end
            PH_INT_NEG: begin
               if (is_dig) begin
                  acc_in   = {60'd0, dv};
                  phase_in = PH_INT_DIG;
               end else begin
                  err = bsp_pkg::ERR_BAD_BYTE;
               end
            end
            PH_INT_DIG: begin
               if (is_dig) begin
                  if (acc_ovf) begin
                     err = bsp_pkg::ERR_OVERFLOW;
                  end else begin
                     acc_in = acc_x10;
                  end
               end else if (req_data_byte == bsp_pkg::CH_END) begin
                  if (sign_ff && (acc_ff > bsp_pkg::NEG_LIMIT)) begin
                     err = bsp_pkg::ERR_NEG;
                  end else begin
                     res.event_res = bsp_pkg::EV_INT;
                     res.value     = acc_ff;
                     res.negative  = sign_ff;
                     fin           = 1'b1;
                  end
               end else begin
                  err = bsp_pkg::ERR_BAD_BYTE;
               end
            end
            PH_STR_LEN: begin
               if (is_dig) begin
                  if (acc_ovf) begin
                     err = bsp_pkg::ERR_OVERFLOW;
                  end else begin
                     acc_in = acc_x10;
                  end
               end else if (req_data_byte == bsp_pkg::CH_COLON) begin
                  left_in       = acc_ff;
                  res.event_res = bsp_pkg::EV_LENGTH;
                  res.value     = acc_ff;
                  res.is_key    = cur_key_ff;
                  if (acc_ff == '0) begin
                     res.string_end = 1'b1;
                     fin            = 1'b1;
                  end else begin
                     phase_in = PH_STR_BYTES;
                  end
               end else begin
                  err = bsp_pkg::ERR_BAD_BYTE;
               end
            end
            PH_STR_BYTES: begin
               res.event_res = bsp_pkg::EV_BYTE;
               res.value     = {56'd0, req_data_byte};
               res.is_key    = cur_key_ff;
               left_in       = left_ff - 1'b1;
               if (left_ff == 64'd1) begin
                  res.string_end = 1'b1;
                  fin            = 1'b1;
               end
            end
            PH_DONE: begin
               err = bsp_pkg::ERR_BAD_BYTE;
            end
            PH_ERROR: begin
               res.event_res = bsp_pkg::EV_PENDING;
            end
         endcase

         // A finished value completes the message at top level, or advances the
         // key/value alternation of an enclosing dict.
         if (fin) begin
            phase_in   = PH_VALUE;
            cur_key_in = 1'b0;
            if (depth_in == '0) begin
               res.message_done = 1'b1;
               phase_in         = PH_DONE;
            end else begin
               stk_cmd.flip = 1'b1;
            end
         end

         if ((err == bsp_pkg::ERR_NONE) && req_last_byte &&
             (phase_in != PH_DONE) && (phase_in != PH_ERROR)) begin
            err = bsp_pkg::ERR_TRUNC;
         end

         if (err != bsp_pkg::ERR_NONE) begin
            phase_in       = PH_ERROR;
            res            = '0;
            res.event_res  = bsp_pkg::EV_ERROR;
            res.error_code = err;
         end
         res.nest_level = depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_expect_ff <= '0;
         max_depth_ff  <= bsp_pkg::MAX_DEPTH_RESET;
         phase_ff      <= PH_VALUE;
         acc_ff        <= '0;
         sign_ff       <= 1'b0;
         left_ff       <= '0;
         depth_ff      <= '0;
         cur_key_ff    <= 1'b0;
      end else begin
         top_expect_ff <= top_expect_in;
         max_depth_ff  <= max_depth_in;
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         sign_ff       <= sign_in;
         left_ff       <= left_in;
         depth_ff      <= depth_in;
         cur_key_ff    <= cur_key_in;
      end
   end

   bsp_stack #(
      .DEPTH (DEPTH)
   ) u_stack (
      .clock    (clock),
      .cmd      (stk_cmd),
      .depth_in (depth_in),
      .top      (stk_top)
   );

   bsp_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .full      (buf_full)
   );

   assign rsp_event_res    = out_data.event_res;
   assign rsp_value        = out_data.value;
   assign rsp_negative     = out_data.negative;
   assign rsp_nest_level   = out_data.nest_level;
   assign rsp_is_key       = out_data.is_key;
   assign rsp_string_end   = out_data.string_end;
   assign rsp_message_done = out_data.message_done;
   assign rsp_error_code   = out_data.error_code;

   `BSP_ASSERT_IMP(a_done_at_top, clock, reset, phase_ff == PH_DONE, depth_ff == '0, "message finished while containers remain open")
   `BSP_ASSERT_NXT(a_error_holds_depth, clock, reset, req_accept && !req_first_byte && (phase_ff == PH_ERROR), depth_ff == $past(depth_ff), "nesting depth moved after an error")
   `BSP_ASSERT_IMP(a_error_code_match, clock, reset, rsp_valid, (rsp_event_res == bsp_pkg::EV_ERROR) == (rsp_error_code != bsp_pkg::ERR_NONE), "error code disagrees with the event")

endmodule

[rtl/bsp_stack.sv]
// Container stack: memory with a registered read, with the top two entries cached in registers.
// Depends on bsp_pkg for the entry and command types.
module bsp_stack #(
   parameter int DEPTH = 32
) (
   input  logic                          clock,
   input  bsp_pkg::stk_cmd_type          cmd,
   input  logic [bsp_pkg::DEPTH_W-1:0]   depth_in,
   output bsp_pkg::stk_entry_type        top
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   bsp_pkg::stk_entry_type mem [DEPTH];

   bsp_pkg::stk_entry_type top_ff, top_in, top_nxt;
   bsp_pkg::stk_entry_type sec_ff, sec_in;
   bsp_pkg::stk_entry_type rd_ff;
   logic                   flip_hit;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;

   // The memory reads the entry third from the top of the next depth (address 0 below three), so a pop
   // can refill the second cache register without waiting.
   always_comb begin
      top_nxt = top_ff;
      sec_in  = sec_ff;
      if (cmd.push) begin
         top_nxt.kind = cmd.kind;
         top_nxt.key  = cmd.kind;
         sec_in       = top_ff;
      end else if (cmd.pop) begin
         top_nxt = sec_ff;
         sec_in  = rd_ff;
      end
      flip_hit = cmd.flip && top_nxt.kind;
      top_in   = top_nxt;
      if (flip_hit) begin
         top_in.key = !top_nxt.key;
      end
      wr_en   = cmd.push || flip_hit;
      wr_addr = AW'(depth_in - 1'b1);
      rd_addr = (depth_in >= 3) ? AW'(depth_in - 2'd3) : '0;
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      sec_ff <= sec_in;
      rd_ff  <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= top_in;
      end
   end

   assign top = top_ff;

endmodule

[rtl/bsp_outbuf.sv]
// Result output register with a skid stage, so the input stall is driven from a register.
// Depends on bsp_pkg for the result type and on the shared assertion macros.
`include "bencode_stream_parser_defines.svh"

module bsp_outbuf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  bsp_pkg::rsp_type in_data,
   input  logic             out_stall,
   output logic             out_valid,
   output bsp_pkg::rsp_type out_data,
   output logic             full
);

   logic             out_valid_ff, out_valid_in;
   bsp_pkg::rsp_type out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   bsp_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             out_free;

   always_comb begin
      out_free      = !out_valid_ff || !out_stall;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || in_valid;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign full      = skid_valid_ff;

   `BSP_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid holds a transaction while the output register is empty")

endmodule
